FILE: src/motor_power_estimator_top_macros.svh
// Assertion macros for the motor power estimator.
// Used by motor_power_estimator_top; expects signals clock and reset in scope.
`ifndef MOTOR_POWER_ESTIMATOR_TOP_MACROS_SVH
`define MOTOR_POWER_ESTIMATOR_TOP_MACROS_SVH

// same-cycle implication
`define MPE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MPE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/mpe_pkg.sv
// Shared types and constants of the motor power estimator.
// No dependencies.
package mpe_pkg;

   localparam int unsigned SQRT3_Q16     = 113512;
   localparam logic [15:0] GAIN_RESET    = 16'd4588;
   localparam logic [15:0] MIN_BUS_RESET = 16'd3;

   localparam logic REG_GAIN = 1'b0;
   localparam logic REG_MIN  = 1'b1;

   typedef enum logic [3:0] {
      OP_NONE, OP_SQA, OP_SQB, OP_X, OP_Y, OP_Z, OP_T, OP_P,
      OP_D, OP_G, OP_A, OP_DV, OP_MD, OP_MG, OP_MA
   } op_type;

   typedef struct packed {
      logic   accept;
      op_type op;
      logic   load_out;
   } cmd_type;

   typedef struct packed {
      logic sqrt_busy;
      logic div_busy;
   } status_type;

endpackage

FILE: src/mpe_sqrt.sv
// Bit-serial integer square root: floor(sqrt(radicand * 2^32)), one root bit a cycle.
// No dependencies.
module mpe_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] radicand,
   output logic        busy,
   output logic [31:0] root
);

   logic [63:0] rad_ff, rad_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [35:0] rem_t, trial;

   always_comb begin
      rem_t   = {rem_ff, rad_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rad_in  = {radicand, 32'd0};
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[61:0], 2'b00};
         if (rem_t >= trial) begin
            rem_in  = 34'(rem_t - trial);
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem_t[33:0];
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

FILE: src/mpe_div.sv
// Serial signed divider with 16-bit saturation: dividend / divisor, truncated; zero when enable is low.
// No dependencies.
module mpe_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               enable,
   input  logic signed [47:0] dividend,
   input  logic        [15:0] divisor,
   output logic               busy,
   output logic signed [15:0] quotient
);

   logic [30:0]        rem_ff, rem_in;
   logic [30:0]        dsh_ff, dsh_in;
   logic [14:0]        q_ff, q_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   logic               busy_ff, busy_in;
   logic signed [15:0] res_ff, res_in;
   logic [47:0]        mag, lim;

   always_comb begin
      mag     = dividend[47] ? 48'(-dividend) : 48'(dividend);
      lim     = {17'd0, divisor, 15'd0};
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      res_in  = res_ff;
      if (start) begin
         neg_in = dividend[47];
         rem_in = mag[30:0];
         dsh_in = {1'b0, divisor, 14'd0};
         q_in   = '0;
         cnt_in = '0;
         if (!enable) begin
            res_in = '0;
         end else if (mag >= lim) begin
            res_in = dividend[47] ? 16'sh8000 : 16'sh7fff;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[13:0], 1'b1};
         end else begin
            q_in   = {q_ff[13:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd14) begin
            busy_in = 1'b0;
            res_in  = neg_ff ? -$signed({1'b0, q_in}) : $signed({1'b0, q_in});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign busy     = busy_ff;
   assign quotient = res_ff;

endmodule

FILE: src/mpe_datapath.sv
// Datapath: operand registers, shared 37x18 multiplier, filters, output registers.
// Depends on mpe_pkg, mpe_sqrt, mpe_div.
module mpe_datapath (
   input  logic                clock,
   input  logic                reset,
   input  mpe_pkg::cmd_type    cmd,
   output mpe_pkg::status_type status,
   input  logic [15:0]         duty_a,
   input  logic [15:0]         duty_b,
   input  logic [15:0]         duty_c,
   input  logic [15:0]         bus_voltage,
   input  logic signed [15:0]  current_alpha,
   input  logic signed [15:0]  current_beta,
   input  logic [15:0]         cfg_gain,
   input  logic [15:0]         cfg_min,
   output logic signed [47:0]  filtered_power,
   output logic signed [15:0]  battery_current,
   output logic [15:0]         phase_current
);

   logic signed [15:0] ia_ff, ib_ff;
   logic [15:0]        vb_ff;
   logic signed [17:0] sa_ff;
   logic signed [16:0] sbc_ff;
   logic signed [54:0] prod_ff;
   logic [31:0]        sqa_ff;
   logic signed [33:0] x_ff;
   logic signed [36:0] t_ff, d_ff;
   logic signed [47:0] pacc_ff, pacc_in;
   logic [31:0]        macc_ff, macc_in;
   logic signed [47:0] fp_ff;
   logic signed [15:0] bat_ff;
   logic [15:0]        ph_ff;

   logic signed [36:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [54:0] mul_p;
   logic signed [51:0] inner;
   logic signed [54:0] p_round, acc_round;
   logic signed [36:0] p_val;
   logic signed [32:0] dm;
   logic [31:0]        sq_sum, root;
   logic               sqrt_busy, div_busy;
   logic signed [15:0] quot;

   always_comb begin
      unique case (cmd.op) inside
         mpe_pkg::OP_SQA: begin mul_a = 37'(ia_ff); mul_b = 18'(ia_ff); end
         mpe_pkg::OP_SQB: begin mul_a = 37'(ib_ff); mul_b = 18'(ib_ff); end
         mpe_pkg::OP_X:   begin mul_a = 37'(ia_ff); mul_b = sa_ff; end
         mpe_pkg::OP_Y:   begin mul_a = 37'(ib_ff); mul_b = 18'(sbc_ff); end
         mpe_pkg::OP_Z: begin
            mul_a = prod_ff[36:0];
            mul_b = 18'(mpe_pkg::SQRT3_Q16);
         end
         mpe_pkg::OP_P:   begin mul_a = t_ff; mul_b = $signed({2'b00, vb_ff}); end
         mpe_pkg::OP_G, mpe_pkg::OP_MG: begin
            mul_a = d_ff;
            mul_b = $signed({2'b00, cfg_gain});
         end
         default:         begin mul_a = '0; mul_b = '0; end
      endcase
      mul_p     = mul_a * mul_b;
      sq_sum    = sqa_ff + prod_ff[31:0];
      inner     = $signed({{2{x_ff[33]}}, x_ff, 16'd0}) + prod_ff[51:0] + 52'sd32768;
      p_round   = prod_ff + 55'sd65536;
      p_val     = p_round[53:17];
      acc_round = prod_ff + 55'sd32768;
      dm        = $signed({1'b0, root}) - $signed({1'b0, macc_ff});
      pacc_in   = pacc_ff;
      macc_in   = macc_ff;
      if (cmd.op == mpe_pkg::OP_A) begin
         pacc_in = pacc_ff + {{9{acc_round[54]}}, acc_round[54:16]};
      end
      if (cmd.op == mpe_pkg::OP_MA) begin
         macc_in = macc_ff + acc_round[47:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pacc_ff <= '0;
         macc_ff <= '0;
      end else begin
         pacc_ff <= pacc_in;
         macc_ff <= macc_in;
      end
      if (cmd.accept) begin
         ia_ff  <= current_alpha;
         ib_ff  <= current_beta;
         vb_ff  <= bus_voltage;
         sa_ff  <= $signed({1'b0, duty_a, 1'b0}) - $signed({2'b00, duty_b})
                   - $signed({2'b00, duty_c});
         sbc_ff <= $signed({1'b0, duty_b}) - $signed({1'b0, duty_c});
      end
      prod_ff <= mul_p;
      if (cmd.op == mpe_pkg::OP_SQB) sqa_ff <= prod_ff[31:0];
      if (cmd.op == mpe_pkg::OP_Y)   x_ff   <= prod_ff[33:0];
      if (cmd.op == mpe_pkg::OP_T)   t_ff   <= {inner[51], inner[51:16]};
      if (cmd.op == mpe_pkg::OP_D)   d_ff   <= p_val - pacc_ff[36:0];
      if (cmd.op == mpe_pkg::OP_MD)  d_ff   <= {{4{dm[32]}}, dm};
      if (cmd.load_out) begin
         fp_ff  <= pacc_ff;
         bat_ff <= quot;
         ph_ff  <= macc_ff[31:16];
      end
   end

   mpe_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == mpe_pkg::OP_X),
      .radicand (sq_sum),
      .busy     (sqrt_busy),
      .root     (root)
   );

   mpe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == mpe_pkg::OP_DV),
      .enable   (vb_ff > cfg_min),
      .dividend (pacc_ff),
      .divisor  (vb_ff),
      .busy     (div_busy),
      .quotient (quot)
   );

   assign status.sqrt_busy = sqrt_busy;
   assign status.div_busy  = div_busy;
   assign filtered_power   = fp_ff;
   assign battery_current  = bat_ff;
   assign phase_current    = ph_ff;

endmodule

FILE: src/mpe_ctrl.sv
// Controller: sequences the datapath steps and owns both handshakes.
// Depends on mpe_pkg.
module mpe_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  mpe_pkg::status_type status,
   output mpe_pkg::cmd_type    cmd
);

   typedef enum logic [16:0] {
      ST_IDLE = 17'h00001, ST_SQA = 17'h00002, ST_SQB = 17'h00004,
      ST_X    = 17'h00008, ST_Y   = 17'h00010, ST_Z   = 17'h00020,
      ST_T    = 17'h00040, ST_P   = 17'h00080, ST_D   = 17'h00100,
      ST_G    = 17'h00200, ST_A   = 17'h00400, ST_DV  = 17'h00800,
      ST_WAIT = 17'h01000, ST_MD  = 17'h02000, ST_MG  = 17'h04000,
      ST_MA   = 17'h08000, ST_OUT = 17'h10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd.accept   = 1'b0;
      cmd.op       = mpe_pkg::OP_NONE;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) state_in = ST_SQA;
         end
         ST_SQA: begin cmd.op = mpe_pkg::OP_SQA; state_in = ST_SQB; end
         ST_SQB: begin cmd.op = mpe_pkg::OP_SQB; state_in = ST_X; end
         ST_X:   begin cmd.op = mpe_pkg::OP_X;   state_in = ST_Y; end
         ST_Y:   begin cmd.op = mpe_pkg::OP_Y;   state_in = ST_Z; end
         ST_Z:   begin cmd.op = mpe_pkg::OP_Z;   state_in = ST_T; end
         ST_T:   begin cmd.op = mpe_pkg::OP_T;   state_in = ST_P; end
         ST_P:   begin cmd.op = mpe_pkg::OP_P;   state_in = ST_D; end
         ST_D:   begin cmd.op = mpe_pkg::OP_D;   state_in = ST_G; end
         ST_G:   begin cmd.op = mpe_pkg::OP_G;   state_in = ST_A; end
         ST_A:   begin cmd.op = mpe_pkg::OP_A;   state_in = ST_DV; end
         ST_DV:  begin cmd.op = mpe_pkg::OP_DV;  state_in = ST_WAIT; end
         ST_WAIT: begin
            if (!status.sqrt_busy && !status.div_busy) state_in = ST_MD;
         end
         ST_MD:  begin cmd.op = mpe_pkg::OP_MD;  state_in = ST_MG; end
         ST_MG:  begin cmd.op = mpe_pkg::OP_MG;  state_in = ST_MA; end
         ST_MA:  begin cmd.op = mpe_pkg::OP_MA;  state_in = ST_OUT; end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/motor_power_estimator_top.sv
// Motor power estimator top level: APB registers, controller and datapath.
// Depends on mpe_pkg, mpe_ctrl, mpe_datapath and the assertion macro header.
//
// Input transfer (req_*): three Q0.16 duties, bus voltage, alpha/beta currents.
// Result transfer (rsp_*): filtered power, battery current, phase current.
// One item at a time: req_ready is high only while the sequencer is idle.
// After the accepting edge the sequencer runs two squares, then starts the
// bit-serial square root; the power products on the shared multiplier and the
// divider run while it iterates. Once both are idle the magnitude filter steps
// run, and loading the result into the output register raises rsp_valid.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, the following item finishes and holds in
// its last step until the output register frees.
// Reset (synchronous) clears both filter accumulators, loads the register
// defaults (gain 4588, minimum bus voltage 3) and drops rsp_valid.
// Registers: filter_gain at address 0, min_bus_voltage at address 4.
`include "motor_power_estimator_top_macros.svh"
module motor_power_estimator_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_duty_a,
   input  logic [15:0]        req_duty_b,
   input  logic [15:0]        req_duty_c,
   input  logic [15:0]        req_bus_voltage,
   input  logic signed [15:0] req_current_alpha,
   input  logic signed [15:0] req_current_beta,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [47:0] rsp_filtered_power,
   output logic signed [15:0] rsp_battery_current,
   output logic [15:0]        rsp_phase_current,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [15:0]         gain_ff, min_ff;
   logic                wr;
   mpe_pkg::cmd_type    cmd;
   mpe_pkg::status_type status;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= mpe_pkg::GAIN_RESET;
         min_ff  <= mpe_pkg::MIN_BUS_RESET;
      end else if (wr) begin
         unique case (paddr[2])
            mpe_pkg::REG_GAIN: gain_ff <= pwdata[15:0];
            mpe_pkg::REG_MIN:  min_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         mpe_pkg::REG_GAIN: prdata = {16'd0, gain_ff};
         mpe_pkg::REG_MIN:  prdata = {16'd0, min_ff};
         default:           prdata = '0;
      endcase
   end

   mpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mpe_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .duty_a          (req_duty_a),
      .duty_b          (req_duty_b),
      .duty_c          (req_duty_c),
      .bus_voltage     (req_bus_voltage),
      .current_alpha   (req_current_alpha),
      .current_beta    (req_current_beta),
      .cfg_gain        (gain_ff),
      .cfg_min         (min_ff),
      .filtered_power  (rsp_filtered_power),
      .battery_current (rsp_battery_current),
      .phase_current   (rsp_phase_current)
   );

   `MPE_ASSERT_NOW(a_accept_units_idle, req_valid && req_ready,
      !status.sqrt_busy && !status.div_busy, "item accepted while a unit is busy")
   `MPE_ASSERT_NOW(a_load_units_idle, cmd.load_out,
      !status.sqrt_busy && !status.div_busy, "result loaded before units finished")
   `MPE_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready,
      !req_ready, "ready stayed high after a transfer")

endmodule

FILE: tb/motor_power_estimator_top_tb.sv
// Self-checking testbench for motor_power_estimator_top: a bit-exact power and
// magnitude filter predictor in SV feeds a result queue checked on every rsp transfer.
// Depends on mpe_pkg and the motor_power_estimator_top RTL.
`timescale 1ns / 1ps
module motor_power_estimator_top_tb;

   localparam logic [2:0] ADDR_GAIN   = {1'b0, mpe_pkg::REG_GAIN, 2'b00};
   localparam logic [2:0] ADDR_MIN    = {1'b0, mpe_pkg::REG_MIN, 2'b00};
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 60;

   typedef struct packed {
      logic [15:0]        duty_a;
      logic [15:0]        duty_b;
      logic [15:0]        duty_c;
      logic [15:0]        bus_voltage;
      logic signed [15:0] current_alpha;
      logic signed [15:0] current_beta;
   } motor_sample_type;

   typedef struct packed {
      logic signed [47:0] filtered_power;
      logic signed [15:0] battery_current;
      logic [15:0]        phase_current;
   } power_estimate_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [15:0] req_duty_a = 0, req_duty_b = 0, req_duty_c = 0, req_bus_voltage = 0;
   logic signed [15:0] req_current_alpha = 0, req_current_beta = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [47:0] rsp_filtered_power;
   logic signed [15:0] rsp_battery_current;
   logic [15:0] rsp_phase_current;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [2:0] paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic pready;

   motor_power_estimator_top dut (.*);

   // predictor state
   logic [15:0] gain_q16 = mpe_pkg::GAIN_RESET;
   logic [15:0] min_bus = mpe_pkg::MIN_BUS_RESET;
   longint power_acc = 0;
   longint magnitude_acc = 0;

   power_estimate_type expected_estimates[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches = 0;
   int transfers_checked = 0;
   int samples_sent = 0;
   int cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint round_shift(longint x, int n);
      return (x + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic longint lowpass_step(longint acc, longint x, logic [15:0] g);
      return acc + round_shift((x - acc) * longint'({48'd0, g}), 16);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic power_estimate_type estimate_power(motor_sample_type s);
      longint ia, ib, vb, sa, sbc, t, p, m, ibat;
      longint unsigned sq;
      power_estimate_type e;
      ia = s.current_alpha;
      ib = s.current_beta;
      vb = {48'd0, s.bus_voltage};
      sa = 2 * longint'({48'd0, s.duty_a}) - longint'({48'd0, s.duty_b})
           - longint'({48'd0, s.duty_c});
      sbc = longint'({48'd0, s.duty_b}) - longint'({48'd0, s.duty_c});
      t = round_shift(ia * sa * 65536 + ib * sbc * longint'(mpe_pkg::SQRT3_Q16), 16);
      p = round_shift(t * vb, 17);
      power_acc = lowpass_step(power_acc, p, gain_q16);
      sq = longint'(ia * ia + ib * ib);
      m = longint'(int_sqrt(sq << 32));
      magnitude_acc = lowpass_step(magnitude_acc, m, gain_q16) & 64'hFFFF_FFFF;
      ibat = 0;
      if (vb > longint'({48'd0, min_bus})) begin
         ibat = power_acc / vb;
         if (ibat > 32767) ibat = 32767;
         if (ibat < -32768) ibat = -32768;
      end
      e.filtered_power = power_acc[47:0];
      e.battery_current = ibat[15:0];
      e.phase_current = magnitude_acc[31:16];
      return e;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 0;
      else
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      power_estimate_type want, got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_filtered_power, rsp_battery_current, rsp_phase_current};
         transfers_checked++;
         if (expected_estimates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transfer: power %0d ibat %0d iph %0d",
                        got.filtered_power, got.battery_current, got.phase_current);
         end else begin
            want = expected_estimates.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: power %0d/%0d ibat %0d/%0d iph %0d/%0d (exp/act)",
                           transfers_checked, want.filtered_power, got.filtered_power,
                           want.battery_current, got.battery_current,
                           want.phase_current, got.phase_current);
            end
         end
      end
   end

   task automatic send_sample(motor_sample_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_duty_a <= s.duty_a;
      req_duty_b <= s.duty_b;
      req_duty_c <= s.duty_c;
      req_bus_voltage <= s.bus_voltage;
      req_current_alpha <= s.current_alpha;
      req_current_beta <= s.current_beta;
      do @(posedge clock); while (!req_ready);
      expected_estimates.push_back(estimate_power(s));
      samples_sent++;
   endtask

   task automatic drain;
      req_valid <= 0;
      while (expected_estimates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      drain();
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      if (addr == ADDR_GAIN) gain_q16 = value[15:0];
      else if (addr == ADDR_MIN) min_bus = value[15:0];
   endtask

   function automatic motor_sample_type make_sample(int d1, int d2, int d3, int vb,
                                                    int ia, int ib);
      motor_sample_type s;
      s.duty_a = d1[15:0];
      s.duty_b = d2[15:0];
      s.duty_c = d3[15:0];
      s.bus_voltage = vb[15:0];
      s.current_alpha = ia[15:0];
      s.current_beta = ib[15:0];
      return s;
   endfunction

   function automatic motor_sample_type random_sample();
      motor_sample_type s;
      s = {$urandom, $urandom, $urandom};
      case ($urandom_range(3))
         0: s.bus_voltage = 16'($urandom_range(8));
         1: s.bus_voltage = 16'($urandom_range(300));
         default: ;
      endcase
      if ($urandom_range(9) == 0) s.current_alpha = 16'sh8000;
      if ($urandom_range(9) == 0) s.current_beta = 16'sh7FFF;
      return s;
   endfunction

   task automatic test_directed;
      send_sample(make_sample(0, 0, 0, 0, 0, 0));
      send_sample(make_sample(65535, 0, 0, 65535, 32767, 0));
      send_sample(make_sample(65535, 0, 0, 65535, -32768, -32768));
      send_sample(make_sample(0, 65535, 65535, 65535, 32767, 32767));
      send_sample(make_sample(0, 65535, 0, 65535, 0, -32768));
      send_sample(make_sample(0, 0, 65535, 65535, 0, 32767));
      send_sample(make_sample(32768, 32768, 32768, 24000, 500, -500));
      send_sample(make_sample(65535, 0, 0, 3, 32767, 0));
      send_sample(make_sample(65535, 0, 0, 4, 32767, 0));
      send_sample(make_sample(0, 65535, 65535, 4, 32767, 32767));
      send_sample(make_sample(0, 65535, 65535, 1, -32768, 0));
      send_sample(make_sample(65535, 65535, 0, 2, 32767, -32768));
      send_sample(make_sample(40000, 20000, 10000, 12800, -1, 1));
   endtask

   task automatic test_gain_settings;
      csr_write(ADDR_GAIN, 0);
      repeat (4) send_sample(random_sample());
      csr_write(ADDR_GAIN, 32'hFFFF);
      csr_write(ADDR_MIN, 0);
      send_sample(make_sample(0, 0, 0, 0, 0, 0));
      send_sample(make_sample(65535, 0, 0, 1, 32767, 32767));
      repeat (4) send_sample(random_sample());
      csr_write(ADDR_MIN, 32'hFFFF);
      repeat (4) send_sample(random_sample());
      send_sample(random_sample());
      csr_write(ADDR_GAIN, 1);
      csr_write(ADDR_MIN, 32'hFFFF_0100);
      repeat (4) send_sample(random_sample());
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 150 == 149) begin
            csr_write(ADDR_GAIN, $urandom_range(3) == 0 ? $urandom : $urandom_range(8000));
            csr_write(ADDR_MIN, $urandom_range(3) == 0 ? $urandom : $urandom_range(300));
         end
         if (i == count / 2) drain();
         send_sample(random_sample());
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_idle_pct = 23;
      recv_idle_pct = 47;
      test_directed();
      test_gain_settings();
      csr_write(ADDR_GAIN, mpe_pkg::GAIN_RESET);
      csr_write(ADDR_MIN, mpe_pkg::MIN_BUS_RESET);
      test_random(540);
      send_idle_pct = 47;
      recv_idle_pct = 23;
      test_random(540);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(540);
      drain();
      $display("%0d samples sent, %0d estimates checked, %0d mismatches", samples_sent,
               transfers_checked, mismatches);
      $display("covered gain/threshold extremes, low bus cutoff, saturation, stalls");
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
